### sv/ipv4_header_parse_check_assert.svh
// Assertion macros for the IPv4 header parse and check block.
// Included by the RTL files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef IPV4_HEADER_PARSE_CHECK_ASSERT_SVH
`define IPV4_HEADER_PARSE_CHECK_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off during reset
`define IPV4HP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ipv4hp check failed");
// Next-cycle implication, sampled on clk, off during reset
`define IPV4HP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ipv4hp check failed");
`else
`define IPV4HP_ASSERT_NOW(label, ante, cons)
`define IPV4HP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### sv/ipv4hp_pkg.sv
// Shared types and constants for the IPv4 header parse and check block.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package ipv4hp_pkg;

  // Result status codes, in check order
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_VERSION   = 3'd2,
    ST_HDR_LEN   = 3'd3,
    ST_TOTAL_LEN = 3'd4
  } status_t;

  localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
  localparam logic [15:0] MIN_HDR_BYTES = 16'd20;
  localparam logic [3:0]  MIN_IHL       = 4'd5;
  localparam logic [3:0]  IP_VERSION    = 4'd4;
  localparam logic [16:0] SUM_ALL_ONES  = 17'h0FFFF;

endpackage

`default_nettype wire

### sv/ipv4hp_if.sv
// Valid/ready channel interfaces for the IPv4 header parse and check block.
// Depends on ipv4hp_pkg for the status type.
`default_nettype none

// Byte stream in: one captured byte per transfer
interface ipv4hp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last;

  modport source (output valid, output byte_in, output last, input ready);
  modport sink   (input valid, input byte_in, input last, output ready);
endinterface

// Parse result out: one transfer per datagram
interface ipv4hp_out_if;
  logic                 valid;
  logic                 ready;
  ipv4hp_pkg::status_t  status;
  logic [3:0]           version;
  logic [3:0]           header_words;
  logic [7:0]           time_to_live;
  logic [7:0]           protocol_number;
  logic [15:0]          datagram_length;
  logic [2:0]           frag_flags;
  logic [12:0]          frag_offset;
  logic                 checksum_ok;
  logic [31:0]          source_addr;
  logic [31:0]          dest_addr;
  logic [15:0]          payload_length;

  modport source (
    output valid, output status, output version, output header_words,
    output time_to_live, output protocol_number, output datagram_length,
    output frag_flags, output frag_offset, output checksum_ok,
    output source_addr, output dest_addr, output payload_length,
    input ready
  );
  modport sink (
    input valid, input status, input version, input header_words,
    input time_to_live, input protocol_number, input datagram_length,
    input frag_flags, input frag_offset, input checksum_ok,
    input source_addr, input dest_addr, input payload_length,
    output ready
  );
endinterface

`default_nettype wire

### sv/ipv4_header_parse_check.sv
// IPv4 header parser with ones' complement header checksum check (top level).
// Depends on ipv4hp_pkg, ipv4hp_if.sv and ipv4_header_parse_check_assert.svh.
//
// Usage:
//   in_chan carries one captured datagram byte per transfer, in wire order, with
//   last set on the final captured byte. out_chan carries one result per
//   datagram: status, the latched header fields, checksum_ok and payload_length.
//   Fields other than status read zero when status is not ok.
// Timing:
//   Each byte lands in an input register, then one short update pass moves the
//   count, running sum and field latches. The result registers load as the last
//   byte leaves the input register. One byte per cycle is sustained unless a last
//   byte stalls; the single update pass on the per-datagram state sets the rate.
// Reset (synchronous, rst_n low): count, sum, latched fields and both valid
//   flags clear; the next byte is taken as byte 0 of a new datagram.
// Stall: while a result waits on out_chan, bytes that are not last keep
//   flowing. A last byte waits in the input register until the pending result
//   is transferred, and in_chan.ready drops behind it.
`default_nettype none

`include "ipv4_header_parse_check_assert.svh"

module ipv4_header_parse_check (
  input  wire           clk,
  input  wire           rst_n,
  ipv4hp_in_if.sink     in_chan,
  ipv4hp_out_if.source  out_chan
);

  // Input register
  logic        in_v_r;
  logic [7:0]  in_byte_r;
  logic        in_last_r;

  // Per-datagram state
  logic [15:0] cnt_r,   cnt_nxt;
  logic [20:0] sum_r,   sum_nxt;
  logic [7:0]  hold_r,  hold_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [15:0] tlen_r,  tlen_nxt;
  logic [15:0] frag_r,  frag_nxt;
  logic [7:0]  ttl_r,   ttl_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] src_r,   src_nxt;
  logic [31:0] dst_r,   dst_nxt;

  // Result register
  logic                out_v_r;
  ipv4hp_pkg::status_t st_r,   st_nxt;
  logic [3:0]          ver_r,  ver_nxt;
  logic [3:0]          ihl_r,  ihl_nxt;
  logic [7:0]          rttl_r, rttl_nxt;
  logic [7:0]          rpro_r, rpro_nxt;
  logic [15:0]         rlen_r, rlen_nxt;
  logic [2:0]          rflg_r, rflg_nxt;
  logic [12:0]         roff_r, roff_nxt;
  logic                rck_r,  rck_nxt;
  logic [31:0]         rsrc_r, rsrc_nxt;
  logic [31:0]         rdst_r, rdst_nxt;
  logic [15:0]         rpay_r, rpay_nxt;

  logic        proc_fire;
  logic [5:0]  hdr_bytes;
  logic [15:0] hdr_bytes_w;
  logic [16:0] fold1;
  logic [16:0] fold2;
  logic [15:0] eff_len;
  logic        stat_ok;

  // Process the held byte unless it is a last byte with a result still waiting
  assign proc_fire   = in_v_r && !(in_last_r && out_v_r && !out_chan.ready);
  assign in_chan.ready = !in_v_r || proc_fire;

  // Update the per-datagram state for the held byte
  always_comb begin
    first_nxt = first_r;
    hold_nxt  = hold_r;
    sum_nxt   = sum_r;
    tlen_nxt  = tlen_r;
    frag_nxt  = frag_r;
    ttl_nxt   = ttl_r;
    proto_nxt = proto_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;

    if (cnt_r == 16'd0) begin
      first_nxt = in_byte_r;
    end
    hdr_bytes   = {first_nxt[3:0], 2'b00};
    hdr_bytes_w = {10'd0, hdr_bytes};

    // Gather header words: even byte held, odd byte completes the word
    if (cnt_r < hdr_bytes_w) begin
      if (!cnt_r[0]) begin
        hold_nxt = in_byte_r;
      end else begin
        sum_nxt = sum_r + {5'd0, hold_r, in_byte_r};
      end
    end

    // Latch fixed header fields by byte position
    if (cnt_r == 16'd2 || cnt_r == 16'd3) begin
      tlen_nxt = {tlen_r[7:0], in_byte_r};
    end else if (cnt_r == 16'd6 || cnt_r == 16'd7) begin
      frag_nxt = {frag_r[7:0], in_byte_r};
    end else if (cnt_r == 16'd8) begin
      ttl_nxt = in_byte_r;
    end else if (cnt_r == 16'd9) begin
      proto_nxt = in_byte_r;
    end else if (cnt_r >= 16'd12 && cnt_r <= 16'd15) begin
      src_nxt = {src_r[23:0], in_byte_r};
    end else if (cnt_r >= 16'd16 && cnt_r <= 16'd19) begin
      dst_nxt = {dst_r[23:0], in_byte_r};
    end

    // Saturating byte count
    cnt_nxt = (cnt_r == ipv4hp_pkg::COUNT_MAX) ? cnt_r : cnt_r + 16'd1;
  end

  // Build the result from the updated state
  always_comb begin
    ver_nxt = first_nxt[7:4];
    ihl_nxt = first_nxt[3:0];

    if (cnt_nxt < ipv4hp_pkg::MIN_HDR_BYTES) begin
      st_nxt = ipv4hp_pkg::ST_SHORT;
    end else if (ver_nxt != ipv4hp_pkg::IP_VERSION) begin
      st_nxt = ipv4hp_pkg::ST_VERSION;
    end else if (ihl_nxt < ipv4hp_pkg::MIN_IHL || cnt_nxt < hdr_bytes_w) begin
      st_nxt = ipv4hp_pkg::ST_HDR_LEN;
    end else if (tlen_nxt < hdr_bytes_w) begin
      st_nxt = ipv4hp_pkg::ST_TOTAL_LEN;
    end else begin
      st_nxt = ipv4hp_pkg::ST_OK;
    end
    stat_ok = (st_nxt == ipv4hp_pkg::ST_OK);

    // Fold the running sum twice into 16 bits
    fold1   = {1'b0, sum_nxt[15:0]} + {12'd0, sum_nxt[20:16]};
    fold2   = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
    eff_len = (tlen_nxt < cnt_nxt) ? tlen_nxt : cnt_nxt;

    rck_nxt  = stat_ok && (fold2 == ipv4hp_pkg::SUM_ALL_ONES);
    rttl_nxt = stat_ok ? ttl_nxt : 8'd0;
    rpro_nxt = stat_ok ? proto_nxt : 8'd0;
    rlen_nxt = stat_ok ? tlen_nxt : 16'd0;
    rflg_nxt = stat_ok ? frag_nxt[15:13] : 3'd0;
    roff_nxt = stat_ok ? frag_nxt[12:0] : 13'd0;
    rsrc_nxt = stat_ok ? src_nxt : 32'd0;
    rdst_nxt = stat_ok ? dst_nxt : 32'd0;
    rpay_nxt = stat_ok ? (eff_len - hdr_bytes_w) : 16'd0;
    if (!stat_ok) begin
      ver_nxt = 4'd0;
      ihl_nxt = 4'd0;
    end
  end

  // Input register: take a byte whenever the slot is free or draining
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_byte_r <= in_chan.byte_in;
      in_last_r <= in_chan.last;
    end
  end

  // Per-datagram state: advance on each processed byte, clear after the last
  always_ff @(posedge clk) begin
    if (!rst_n || (proc_fire && in_last_r)) begin
      cnt_r   <= '0;
      sum_r   <= '0;
      hold_r  <= '0;
      first_r <= '0;
      tlen_r  <= '0;
      frag_r  <= '0;
      ttl_r   <= '0;
      proto_r <= '0;
      src_r   <= '0;
      dst_r   <= '0;
    end else if (proc_fire) begin
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      hold_r  <= hold_nxt;
      first_r <= first_nxt;
      tlen_r  <= tlen_nxt;
      frag_r  <= frag_nxt;
      ttl_r   <= ttl_nxt;
      proto_r <= proto_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
    end
  end

  // Result valid: set on a processed last byte, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (proc_fire && in_last_r) begin
      out_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && in_last_r) begin
      st_r   <= st_nxt;
      ver_r  <= ver_nxt;
      ihl_r  <= ihl_nxt;
      rttl_r <= rttl_nxt;
      rpro_r <= rpro_nxt;
      rlen_r <= rlen_nxt;
      rflg_r <= rflg_nxt;
      roff_r <= roff_nxt;
      rck_r  <= rck_nxt;
      rsrc_r <= rsrc_nxt;
      rdst_r <= rdst_nxt;
      rpay_r <= rpay_nxt;
    end
  end

  assign out_chan.valid           = out_v_r;
  assign out_chan.status          = st_r;
  assign out_chan.version         = ver_r;
  assign out_chan.header_words    = ihl_r;
  assign out_chan.time_to_live    = rttl_r;
  assign out_chan.protocol_number = rpro_r;
  assign out_chan.datagram_length = rlen_r;
  assign out_chan.frag_flags      = rflg_r;
  assign out_chan.frag_offset     = roff_r;
  assign out_chan.checksum_ok     = rck_r;
  assign out_chan.source_addr     = rsrc_r;
  assign out_chan.dest_addr       = rdst_r;
  assign out_chan.payload_length  = rpay_r;

  // A failed check leaves no checksum or payload length in the result
  `IPV4HP_ASSERT_NOW(a_fail_zeroes, out_v_r && st_r != ipv4hp_pkg::ST_OK, rpay_r == 16'd0 && !rck_r)
  // An ok result always has version 4 and at least five header words
  `IPV4HP_ASSERT_NOW(a_ok_fields, out_v_r && st_r == ipv4hp_pkg::ST_OK, ver_r == ipv4hp_pkg::IP_VERSION && ihl_r >= ipv4hp_pkg::MIN_IHL)
  // The byte count restarts after each datagram
  `IPV4HP_ASSERT_NEXT(a_count_clear, proc_fire && in_last_r, cnt_r == 16'd0 && sum_r == 21'd0)
  // A byte that is not last advances the count until saturation
  `IPV4HP_ASSERT_NEXT(a_count_step, proc_fire && !in_last_r && cnt_r != ipv4hp_pkg::COUNT_MAX, cnt_r == $past(cnt_r) + 16'd1)
  // A last byte stalls only behind a pending result
  `IPV4HP_ASSERT_NOW(a_stall_cause, in_v_r && !proc_fire, in_last_r && out_v_r)

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the IPv4 header parser with header checksum check.
// Depends on ipv4hp_pkg, the channel interfaces in ipv4hp_if.sv and the top level.
// Drives datagram bytes with random gaps and checks each result against a byte-level predictor.
`default_nettype none

module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 250;
  localparam int RANDOM_BYTES = 400;
  localparam int CALM_BYTES  = 330;

  // Fill patterns for the bytes a directed row does not set
  localparam int FILL_RANDOM = 0;
  localparam int FILL_ZEROS  = 1;
  localparam int FILL_ONES   = 2;

  typedef struct packed {
    ipv4hp_pkg::status_t status;
    logic [3:0]  version;
    logic [3:0]  header_words;
    logic [7:0]  time_to_live;
    logic [7:0]  protocol_number;
    logic [15:0] datagram_length;
    logic [2:0]  frag_flags;
    logic [12:0] frag_offset;
    logic        checksum_ok;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
    logic [15:0] payload_length;
  } ip_result_t;

  // One directed datagram: header shape, capture length, and a typed-in status
  typedef struct packed {
    logic [3:0]  ver;
    logic [3:0]  ihl;
    logic [15:0] tot;
    logic [16:0] cap;
    logic        csum_good;
    logic [1:0]  fill;
    logic        pinned;
    ipv4hp_pkg::status_t pin_status;
  } frame_row_t;

  typedef struct {
    int unsigned seq;
    ip_result_t  r;
  } pinned_result_t;

  logic clk;
  logic rst_n;

  ipv4hp_in_if  in_chan ();
  ipv4hp_out_if out_chan ();

  ipv4_header_parse_check u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  frame_row_t directed_rows [20] = '{
    // after reset: one byte only
    '{4'd4, 4'd5, 16'd20, 17'd1, 1'b1, 2'd0, 1'b1, ipv4hp_pkg::ST_SHORT},
    '{4'd4, 4'd5, 16'd20, 17'd19, 1'b1, 2'd0, 1'b1, ipv4hp_pkg::ST_SHORT},
    // short capture wins over bad version and bad IHL
    '{4'd6, 4'd2, 16'd10, 17'd10, 1'b1, 2'd0, 1'b1, ipv4hp_pkg::ST_SHORT},
    '{4'd6, 4'd5, 16'd20, 17'd20, 1'b1, 2'd0, 1'b1, ipv4hp_pkg::ST_VERSION},
    // bad version wins over bad IHL and bad total length
    '{4'd0, 4'd0, 16'd0, 17'd20, 1'b1, 2'd1, 1'b1, ipv4hp_pkg::ST_VERSION},
    '{4'd15, 4'd15, 16'hFFFF, 17'd20, 1'b1, 2'd2, 1'b1, ipv4hp_pkg::ST_VERSION},
    // IHL below five
    '{4'd4, 4'd4, 16'd20, 17'd20, 1'b1, 2'd0, 1'b1, ipv4hp_pkg::ST_HDR_LEN},
    '{4'd4, 4'd0, 16'd0, 17'd24, 1'b1, 2'd0, 1'b1, ipv4hp_pkg::ST_HDR_LEN},
    // header longer than the capture
    '{4'd4, 4'd15, 16'd60, 17'd59, 1'b1, 2'd0, 1'b1, ipv4hp_pkg::ST_HDR_LEN},
    '{4'd4, 4'd5, 16'd19, 17'd20, 1'b1, 2'd0, 1'b1, ipv4hp_pkg::ST_TOTAL_LEN},
    '{4'd4, 4'd5, 16'd0, 17'd20, 1'b1, 2'd2, 1'b1, ipv4hp_pkg::ST_TOTAL_LEN},
    '{4'd4, 4'd6, 16'd23, 17'd30, 1'b1, 2'd0, 1'b1, ipv4hp_pkg::ST_TOTAL_LEN},
    // minimum good header, all other fields zero
    '{4'd4, 4'd5, 16'd20, 17'd20, 1'b1, 2'd1, 1'b0, ipv4hp_pkg::ST_OK},
    // widest header, all ones: largest sum and every field at its top
    '{4'd4, 4'd15, 16'hFFFF, 17'd60, 1'b1, 2'd2, 1'b0, ipv4hp_pkg::ST_OK},
    '{4'd4, 4'd15, 16'd60, 17'd60, 1'b0, 2'd2, 1'b0, ipv4hp_pkg::ST_OK},
    // capture runs past the total length
    '{4'd4, 4'd5, 16'd24, 17'd30, 1'b1, 2'd0, 1'b0, ipv4hp_pkg::ST_OK},
    // total length runs past the capture
    '{4'd4, 4'd5, 16'd100, 17'd24, 1'b1, 2'd0, 1'b0, ipv4hp_pkg::ST_OK},
    '{4'd4, 4'd5, 16'd24, 17'd24, 1'b0, 2'd0, 1'b0, ipv4hp_pkg::ST_OK},
    // options and a payload past the header
    '{4'd4, 4'd7, 16'd40, 17'd40, 1'b1, 2'd0, 1'b0, ipv4hp_pkg::ST_OK},
    // minimum header, all ones in the other fields
    '{4'd4, 4'd5, 16'd20, 17'd20, 1'b1, 2'd2, 1'b0, ipv4hp_pkg::ST_OK}
  };

  // Predictor state, one datagram at a time
  logic [15:0] seen_count;
  logic [20:0] hdr_sum;
  logic [7:0]  word_high;
  logic [7:0]  vers_ihl;
  logic [15:0] total_len;
  logic [15:0] frag_word;
  logic [7:0]  ttl_val;
  logic [7:0]  proto_val;
  logic [31:0] src_val;
  logic [31:0] dst_val;

  ip_result_t     result_q [$];
  pinned_result_t pinned_q [$];
  logic [7:0]     frame_bytes [$];

  int unsigned frames_done;
  int unsigned frames_sent;
  int          errors;
  int          cycles;
  int          hold_req;
  bit          src_idle_en;
  bit          sink_idle_en;

  initial begin
    clk = 1'b0;
    seen_count = '0;
    hdr_sum = '0;
    word_high = '0;
    vers_ihl = '0;
    total_len = '0;
    frag_word = '0;
    ttl_val = '0;
    proto_val = '0;
    src_val = '0;
    dst_val = '0;
    frames_done = 0;
    frames_sent = 0;
    errors = 0;
    cycles = 0;
    hold_req = 0;
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
  end

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, result_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Advance the parser state by one accepted byte; queue the result on the last one
  task automatic parse_byte(input logic [7:0] b, input logic fin);
    int         pos;
    int         hdr;
    int         fold;
    int         eff;
    ip_result_t r;
    pos = seen_count;
    if (pos == 0) vers_ihl = b;
    hdr = vers_ihl[3:0] * 4;
    if (pos < hdr) begin
      if (pos[0] == 1'b0) word_high = b;
      else hdr_sum = hdr_sum + {word_high, b};
    end
    if (pos == 2 || pos == 3) total_len = {total_len[7:0], b};
    else if (pos == 6 || pos == 7) frag_word = {frag_word[7:0], b};
    else if (pos == 8) ttl_val = b;
    else if (pos == 9) proto_val = b;
    else if (pos >= 12 && pos <= 15) src_val = {src_val[23:0], b};
    else if (pos >= 16 && pos <= 19) dst_val = {dst_val[23:0], b};
    if (seen_count != ipv4hp_pkg::COUNT_MAX) seen_count = seen_count + 16'd1;
    if (!fin) return;

    r = '0;
    if (seen_count < ipv4hp_pkg::MIN_HDR_BYTES) r.status = ipv4hp_pkg::ST_SHORT;
    else if (vers_ihl[7:4] != ipv4hp_pkg::IP_VERSION) r.status = ipv4hp_pkg::ST_VERSION;
    else if (vers_ihl[3:0] < ipv4hp_pkg::MIN_IHL || seen_count < hdr)
      r.status = ipv4hp_pkg::ST_HDR_LEN;
    else if (total_len < hdr) r.status = ipv4hp_pkg::ST_TOTAL_LEN;
    else r.status = ipv4hp_pkg::ST_OK;

    if (r.status == ipv4hp_pkg::ST_OK) begin
      fold = hdr_sum[15:0] + hdr_sum[20:16];
      fold = (fold & 'hFFFF) + (fold >> 16);
      eff = (total_len < seen_count) ? total_len : seen_count;
      r.version = vers_ihl[7:4];
      r.header_words = vers_ihl[3:0];
      r.time_to_live = ttl_val;
      r.protocol_number = proto_val;
      r.datagram_length = total_len;
      r.frag_flags = frag_word[15:13];
      r.frag_offset = frag_word[12:0];
      r.checksum_ok = (fold == ipv4hp_pkg::SUM_ALL_ONES);
      r.source_addr = src_val;
      r.dest_addr = dst_val;
      r.payload_length = 16'(eff - hdr);
    end

    // A typed-in result for this datagram overrides the predicted one
    if (pinned_q.size() != 0 && pinned_q[0].seq == frames_done) begin
      result_q.push_back(pinned_q[0].r);
      void'(pinned_q.pop_front());
    end else begin
      result_q.push_back(r);
    end
    frames_done++;

    seen_count = '0;
    hdr_sum = '0;
    word_high = '0;
    vers_ihl = '0;
    total_len = '0;
    frag_word = '0;
    ttl_val = '0;
    proto_val = '0;
    src_val = '0;
    dst_val = '0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want_v, got_v);
    end
  endtask

  // Track both channels on the rising edge
  always @(posedge clk) begin
    ip_result_t want;
    if (in_chan.valid && in_chan.ready) parse_byte(in_chan.byte_in, in_chan.last);
    if (out_chan.valid && out_chan.ready) begin
      if (result_q.size() == 0) begin
        errors++;
        $display("%0t: result transfer with none expected, status %0d", $time,
                 out_chan.status);
      end else begin
        want = result_q.pop_front();
        check_field("status", 32'(want.status), 32'(out_chan.status));
        check_field("version", 32'(want.version), 32'(out_chan.version));
        check_field("header_words", 32'(want.header_words), 32'(out_chan.header_words));
        check_field("time_to_live", 32'(want.time_to_live), 32'(out_chan.time_to_live));
        check_field("protocol_number", 32'(want.protocol_number),
                    32'(out_chan.protocol_number));
        check_field("datagram_length", 32'(want.datagram_length),
                    32'(out_chan.datagram_length));
        check_field("frag_flags", 32'(want.frag_flags), 32'(out_chan.frag_flags));
        check_field("frag_offset", 32'(want.frag_offset), 32'(out_chan.frag_offset));
        check_field("checksum_ok", 32'(want.checksum_ok), 32'(out_chan.checksum_ok));
        check_field("source_addr", want.source_addr, out_chan.source_addr);
        check_field("dest_addr", want.dest_addr, out_chan.dest_addr);
        check_field("payload_length", 32'(want.payload_length),
                    32'(out_chan.payload_length));
      end
    end
  end

  // Result side: random stall bursts plus one long hold on request
  initial begin
    int stall_left;
    int hold_left;
    int holds_served;
    stall_left = 0;
    hold_left = 0;
    holds_served = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_req) begin
        holds_served = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Offer one byte, with an optional gap ahead of it, and hold until the transfer
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    @(negedge clk);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.byte_in <= b;
    in_chan.last <= fin;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    frames_sent++;
  endtask

  // Lay out a datagram header and payload, then cut it to the capture length
  task automatic build_frame(input logic [3:0] ver, input logic [3:0] ihl,
                             input logic [15:0] tot, input int cap,
                             input bit csum_good, input int fill);
    int          len;
    int          hdr;
    int          acc;
    logic [15:0] ck;
    frame_bytes.delete();
    hdr = ihl * 4;
    len = (cap < 20) ? 20 : cap;
    if (len < hdr) len = hdr;
    for (int i = 0; i < len; i++) begin
      if (fill == FILL_ZEROS) frame_bytes.push_back(8'h00);
      else if (fill == FILL_ONES) frame_bytes.push_back(8'hFF);
      else frame_bytes.push_back(8'($urandom_range(0, 255)));
    end
    frame_bytes[0] = {ver, ihl};
    frame_bytes[2] = tot[15:8];
    frame_bytes[3] = tot[7:0];
    if (ihl >= ipv4hp_pkg::MIN_IHL) begin
      frame_bytes[10] = 8'h00;
      frame_bytes[11] = 8'h00;
      acc = 0;
      for (int i = 0; i < hdr; i += 2) acc += {frame_bytes[i], frame_bytes[i + 1]};
      acc = (acc & 'hFFFF) + (acc >> 16);
      acc = (acc & 'hFFFF) + (acc >> 16);
      ck = ~acc[15:0];
      if (!csum_good) ck = ck ^ 16'($urandom_range(1, 65535));
      frame_bytes[10] = ck[15:8];
      frame_bytes[11] = ck[7:0];
    end
    while (frame_bytes.size() > cap) void'(frame_bytes.pop_back());
  endtask

  // Drop valid and hold the sender until every expected result is out
  task automatic drain_results();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (result_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    pinned_result_t pin;
    frame_row_t     row;
    int             rand_bytes;
    int             pick;
    int             ihl_r;
    int             cap_r;
    int             hdr_r;
    int             tot_r;
    bit             hold_done;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.byte_in = 8'h00;
    in_chan.last = 1'b0;
    rand_bytes = 0;
    hold_done = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed datagrams
    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      src_idle_en = (row.cap < 1000);
      build_frame(row.ver, row.ihl, row.tot, int'(row.cap), row.csum_good, int'(row.fill));
      if (row.pinned) begin
        pin.seq = frames_sent;
        pin.r = '0;
        pin.r.status = row.pin_status;
        pinned_q.push_back(pin);
      end
      send_frame();
    end
    src_idle_en = 1'b1;
    drain_results();

    // Random datagrams: mostly well formed, some broken, some noise
    while (rand_bytes < RANDOM_BYTES) begin
      if (rand_bytes >= CALM_BYTES) begin
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
      end
      if (!hold_done && rand_bytes >= 100) begin
        hold_req++;
        hold_done = 1'b1;
      end else if (rand_bytes < CALM_BYTES && frames_sent % 15 == 0) begin
        drain_results();
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        ihl_r = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 15) : 5;
        hdr_r = ihl_r * 4;
        cap_r = hdr_r + $urandom_range(0, 40);
        case ($urandom_range(0, 3))
          0: tot_r = cap_r;
          1: tot_r = $urandom_range(hdr_r, cap_r);
          2: tot_r = $urandom_range(cap_r, 65535);
          default: tot_r = $urandom_range(hdr_r, 65535);
        endcase
        build_frame(ipv4hp_pkg::IP_VERSION, 4'(ihl_r), 16'(tot_r), cap_r,
                    $urandom_range(0, 6) != 0, FILL_RANDOM);
      end else if (pick < 90) begin
        tot_r = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 80) : $urandom_range(0, 65535);
        build_frame(($urandom_range(0, 1) == 0) ? ipv4hp_pkg::IP_VERSION
                                                : 4'($urandom_range(0, 15)),
                    4'($urandom_range(0, 15)), 16'(tot_r), $urandom_range(1, 70),
                    $urandom_range(0, 1) == 1, FILL_RANDOM);
      end else begin
        frame_bytes.delete();
        cap_r = $urandom_range(1, 30);
        for (int i = 0; i < cap_r; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end
      rand_bytes += frame_bytes.size();
      send_frame();
    end

    // Wait out the results still in flight, then the pipeline tail
    drain_results();
    repeat (8) @(negedge clk);
    if (errors == 0 && result_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
